@@ rtl/rar_pkg.sv @@
// Shared types, widths and command codes of the rational accumulator.
package rar_pkg;

    // Value width of the accumulator and operands, and the exact product width
    localparam int unsigned RAR_W  = 32;
    localparam int unsigned RAR_PW = 2 * RAR_W;
    localparam int unsigned RAR_CW = $clog2(RAR_PW);

    // Port field widths of the stream interface
    localparam int unsigned CMD_W       = 2;
    localparam int unsigned FIELD_W     = 32;
    localparam int unsigned OUT_DEN_W   = 31;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET = 2'd0,
        CMD_ADD = 2'd1,
        CMD_SUB = 2'd2,
        CMD_MUL = 2'd3
    } t_cmd;

    // Classified operand: command, sign and magnitudes
    typedef struct packed {
        t_cmd             cmd;
        logic             neg;
        logic [RAR_W-1:0] num;
        logic [RAR_W-1:0] den;
    } t_op;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic valid;
    } t_qstat;

endpackage

@@ rtl/rar_front.sv @@
// Front end: takes input items and classifies the operand into sign and magnitudes.
module rar_front (
    input  logic                               i_tvalid,
    input  logic [rar_pkg::IN_TDATA_W-1:0]     i_tdata,
    output logic                               o_tready,
    input  rar_pkg::t_qstat                    i_qstat,
    output logic                               o_push,
    output rar_pkg::t_op                       o_op
);

    logic signed [rar_pkg::RAR_W-1:0] num_s;
    logic signed [rar_pkg::RAR_W-1:0] den_s;
    logic signed [rar_pkg::RAR_W-1:0] num_e;
    logic signed [rar_pkg::RAR_W-1:0] den_e;

    // Field extraction: only the low value-width bits count
    assign num_s = signed'(i_tdata[rar_pkg::CMD_W +: rar_pkg::RAR_W]);
    assign den_s = signed'(i_tdata[rar_pkg::CMD_W + rar_pkg::FIELD_W +: rar_pkg::RAR_W]);

    // Zero denominator turns the operand into one over one
    always_comb begin
        if (den_s == '0) begin
            num_e = rar_pkg::RAR_W'(1);
            den_e = rar_pkg::RAR_W'(1);
        end else begin
            num_e = num_s;
            den_e = den_s;
        end
    end

    // Sign onto a flag, magnitudes unsigned
    always_comb begin
        o_op.cmd = rar_pkg::t_cmd'(i_tdata[rar_pkg::CMD_W-1:0]);
        o_op.neg = num_e[rar_pkg::RAR_W-1] ^ den_e[rar_pkg::RAR_W-1];
        o_op.num = num_e[rar_pkg::RAR_W-1] ? -num_e : num_e;
        o_op.den = den_e[rar_pkg::RAR_W-1] ? -den_e : den_e;
    end

    assign o_tready = !i_qstat.full;
    assign o_push   = i_tvalid && !i_qstat.full;

endmodule

@@ rtl/rar_fifo.sv @@
// Two-entry queue of classified operands between front and back.
module rar_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rar_pkg::t_op  i_op,
    input  logic          i_pop,
    output rar_pkg::t_op  o_op,
    output rar_pkg::t_qstat o_qstat
);

    rar_pkg::t_op r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_count;
    logic         do_push;
    logic         do_pop;

    assign do_push = i_push && (r_count != 2'd2);
    assign do_pop  = i_pop && (r_count != 2'd0);

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    assign o_op          = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == 2'd2);
    assign o_qstat.valid = (r_count != 2'd0);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue fill count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with fill count");

endmodule

@@ rtl/rar_core.sv @@
// Back end: accumulator, shared multiplier, binary gcd and restoring divider.
module rar_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rar_pkg::t_op                      i_op,
    input  rar_pkg::t_qstat                   i_qstat,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [rar_pkg::RAR_W-1:0]  o_num,
    output logic [rar_pkg::RAR_W-2:0]         o_den,
    output logic                              o_ovf
);

    localparam int unsigned W  = rar_pkg::RAR_W;
    localparam int unsigned PW = rar_pkg::RAR_PW;
    localparam int unsigned CW = rar_pkg::RAR_CW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_D, ST_MUL_A, ST_MUL_B, ST_COMB,
        ST_GINIT, ST_GCD, ST_DIV, ST_CHECK
    } t_state;

    t_state                r_state;
    rar_pkg::t_op          r_op;
    logic signed [W-1:0]   r_acc_num;
    logic [W-2:0]          r_acc_den;
    logic [PW-1:0]         r_t1;
    logic [PW-1:0]         r_t2;
    logic [PW-1:0]         r_rn;
    logic [PW-1:0]         r_rd;
    logic                  r_rneg;
    logic [PW-1:0]         r_ga;
    logic [PW-1:0]         r_gb;
    logic [CW-1:0]         r_k;
    logic [PW-1:0]         r_g;
    logic [PW-1:0]         r_q;
    logic [PW:0]           r_rem;
    logic [CW-1:0]         r_cnt;
    logic                  r_sel_den;
    logic                  r_out_valid;
    logic signed [W-1:0]   r_out_num;
    logic [W-2:0]          r_out_den;
    logic                  r_out_ovf;

    logic                  aneg;
    logic [W-1:0]          an;
    logic [W-1:0]          ad;
    logic [W-1:0]          mul_a;
    logic [W-1:0]          mul_b;
    logic [PW-1:0]         prod;
    logic                  n2;
    logic [PW-1:0]         c_rn;
    logic                  c_rneg;
    logic [PW-1:0]         c_rd;
    logic [PW:0]           rem_sh;
    logic                  q_bit;
    logic [PW:0]           rem_nx;
    logic [PW-1:0]         q_nx;
    logic [PW-1:0]         limit;
    logic                  ovf;
    logic                  out_free;

    // Accumulator seen as sign and magnitude
    assign aneg = r_acc_num[W-1];
    assign an   = aneg ? W'(-r_acc_num) : W'(r_acc_num);
    assign ad   = W'(r_acc_den);

    // Shared multiplier, operands chosen by state
    always_comb begin
        mul_a = ad;
        mul_b = r_op.den;
        case (r_state)
            ST_MUL_A: begin
                mul_a = an;
                mul_b = (r_op.cmd == rar_pkg::CMD_MUL) ? r_op.num : r_op.den;
            end
            ST_MUL_B: begin
                mul_a = r_op.num;
                mul_b = ad;
            end
            default: begin
                mul_a = ad;
                mul_b = r_op.den;
            end
        endcase
    end
    assign prod = PW'(mul_a) * PW'(mul_b);

    // Combine the products into an unreduced signed fraction
    assign n2 = (r_op.cmd == rar_pkg::CMD_SUB) ? !r_op.neg : r_op.neg;
    always_comb begin
        c_rd = r_rd;
        unique case (r_op.cmd)
            rar_pkg::CMD_SET: begin
                c_rneg = r_op.neg;
                c_rn   = PW'(r_op.num);
                c_rd   = PW'(r_op.den);
            end
            rar_pkg::CMD_MUL: begin
                c_rneg = aneg ^ r_op.neg;
                c_rn   = r_t1;
            end
            default: begin
                if (aneg == n2) begin
                    c_rneg = aneg;
                    c_rn   = r_t1 + r_t2;
                end else if (r_t1 >= r_t2) begin
                    c_rneg = aneg;
                    c_rn   = r_t1 - r_t2;
                end else begin
                    c_rneg = n2;
                    c_rn   = r_t2 - r_t1;
                end
            end
        endcase
    end

    // One restoring division step
    assign rem_sh = {r_rem[PW-1:0], r_q[PW-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_g});
    assign rem_nx = q_bit ? (rem_sh - {1'b0, r_g}) : rem_sh;
    assign q_nx   = {r_q[PW-2:0], q_bit};

    // Range check of the reduced fraction
    assign limit = PW'(1) << (W - 1);
    assign ovf   = (r_rd > (limit - PW'(1)))
                || (r_rneg ? (r_rn > limit) : (r_rn > (limit - PW'(1))));

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == ST_IDLE) && i_qstat.valid;

    // Sequencer, accumulator and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc_num   <= W'(1);
            r_acc_den   <= (W-1)'(1);
            r_out_valid <= 1'b0;
        end else begin
            // Result taken and no new one loaded this cycle
            if (r_out_valid && i_ready && r_state != ST_CHECK) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_qstat.valid) begin
                        r_op    <= i_op;
                        r_state <= ST_MUL_D;
                    end
                end
                ST_MUL_D: begin
                    r_rd    <= prod;
                    r_state <= (r_op.cmd == rar_pkg::CMD_SET) ? ST_COMB : ST_MUL_A;
                end
                ST_MUL_A: begin
                    r_t1    <= prod;
                    r_state <= (r_op.cmd == rar_pkg::CMD_MUL) ? ST_COMB : ST_MUL_B;
                end
                ST_MUL_B: begin
                    r_t2    <= prod;
                    r_state <= ST_COMB;
                end
                ST_COMB: begin
                    r_rn    <= c_rn;
                    r_rd    <= c_rd;
                    r_rneg  <= c_rneg;
                    r_state <= ST_GINIT;
                end
                ST_GINIT: begin
                    if (r_rn == '0) begin
                        r_rneg  <= 1'b0;
                        r_rd    <= PW'(1);
                        r_state <= ST_CHECK;
                    end else begin
                        r_ga    <= r_rn;
                        r_gb    <= r_rd;
                        r_k     <= '0;
                        r_state <= ST_GCD;
                    end
                end
                ST_GCD: begin
                    if (r_ga == '0 || r_gb == '0) begin
                        r_g       <= (r_ga | r_gb) << r_k;
                        r_q       <= r_rn;
                        r_rem     <= '0;
                        r_cnt     <= '0;
                        r_sel_den <= 1'b0;
                        r_state   <= ST_DIV;
                    end else if (!r_ga[0] && !r_gb[0]) begin
                        r_ga <= r_ga >> 1;
                        r_gb <= r_gb >> 1;
                        r_k  <= r_k + CW'(1);
                    end else if (!r_ga[0]) begin
                        r_ga <= r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        r_gb <= r_gb >> 1;
                    end else if (r_ga >= r_gb) begin
                        r_ga <= r_ga - r_gb;
                    end else begin
                        r_gb <= r_gb - r_ga;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == CW'(PW - 1)) begin
                        if (!r_sel_den) begin
                            r_rn      <= q_nx;
                            r_q       <= r_rd;
                            r_rem     <= '0;
                            r_cnt     <= '0;
                            r_sel_den <= 1'b1;
                        end else begin
                            r_rd    <= q_nx;
                            r_state <= ST_CHECK;
                        end
                    end else begin
                        r_q   <= q_nx;
                        r_rem <= rem_nx;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                ST_CHECK: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ovf   <= ovf;
                        if (ovf) begin
                            r_out_num <= r_acc_num;
                            r_out_den <= r_acc_den;
                        end else begin
                            r_acc_num <= r_rneg ? -signed'(r_rn[W-1:0])
                                                :  signed'(r_rn[W-1:0]);
                            r_acc_den <= r_rd[W-2:0];
                            r_out_num <= r_rneg ? -signed'(r_rn[W-1:0])
                                                :  signed'(r_rn[W-1:0]);
                            r_out_den <= r_rd[W-2:0];
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_num   = r_out_num;
    assign o_den   = r_out_den;
    assign o_ovf   = r_out_ovf;

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_den != '0)
        else $error("accumulator denominator is zero");

    a_ovf_keeps_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && out_free && ovf) |=>
            ($stable(r_acc_num) && $stable(r_acc_den)))
        else $error("accumulator changed on overflow");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_g != '0))
        else $error("division by zero divisor");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == ST_MUL_D))
        else $error("popped item not started");

endmodule

@@ rtl/rational_accumulator_reduce.sv @@
// The back end runs the operand multiplies, the combine, the bit-serial gcd loop and two
// divides by the gcd in the 64-bit divider; a zero result skips the gcd and the divides.
// The back end works on one item at a time; the two-entry queue in front of it can take
// new items while the back end is busy, until the queue is full.
// Reset (synchronous, active low) sets the accumulator to 1/1 and empties the queue.
// Top level of the rational accumulator with gcd reduction.
module rational_accumulator_reduce (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] command, [33:2] operand_numerator, [65:34] operand_denominator
    input  logic [rar_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] result_numerator, [62:32] result_denominator
    output logic [rar_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] overflow
    output logic [0:0]                          m_axis_tuser
);

    rar_pkg::t_op     front_op;
    rar_pkg::t_op     queue_op;
    rar_pkg::t_qstat  qstat;
    logic             push;
    logic             pop;
    logic signed [rar_pkg::RAR_W-1:0] res_num;
    logic [rar_pkg::RAR_W-2:0]        res_den;
    logic             res_ovf;

    rar_front u_front (
        .i_tvalid (s_axis_tvalid),
        .i_tdata  (s_axis_tdata),
        .o_tready (s_axis_tready),
        .i_qstat  (qstat),
        .o_push   (push),
        .o_op     (front_op)
    );

    rar_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (queue_op),
        .o_qstat (qstat)
    );

    rar_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (queue_op),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_num   (res_num),
        .o_den   (res_den),
        .o_ovf   (res_ovf)
    );

    // Result packing
    assign m_axis_tdata = {1'b0,
                           rar_pkg::OUT_DEN_W'(res_den),
                           rar_pkg::FIELD_W'(res_num)};
    assign m_axis_tuser = res_ovf;

endmodule

@@ tb/sv/rational_accumulator_reduce_tb.sv @@
// Self-checking testbench of the rational accumulator with gcd reduction.
module rational_accumulator_reduce_tb;

    localparam int unsigned NUM_RANDOM  = 1500;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned DRAIN_WAIT  = 600;

    // One expected or observed result item
    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        ovf;
    } t_frac_res;

    // Directed stimulus row; chk set means the typed expectation is compared too
    typedef struct {
        rar_pkg::t_cmd cmd;
        logic [31:0]   n;
        logic [31:0]   d;
        bit            chk;
        t_frac_res     res;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // [1:0] command, [33:2] operand_numerator, [65:34] operand_denominator
    logic [rar_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // [31:0] result_numerator, [62:32] result_denominator
    logic [rar_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    // [0] overflow
    logic [0:0]                      m_axis_tuser;

    rational_accumulator_reduce DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // Predictor state: accumulator fraction
    longint    acc_num;
    longint    acc_den;
    t_frac_res frac_expected_q[$];
    t_frac_res typed_q[$];
    bit        typed_chk_q[$];
    int        err_count;
    int        stall_cycles;
    bit        quiet_phase;
    bit        drain_phase;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
        longint unsigned r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Update the accumulator with one item and return the result item
    function automatic t_frac_res frac_update(rar_pkg::t_cmd cmd, logic [31:0] n,
                                              logic [31:0] d);
        longint          on_s, od_s;
        bit              oneg, aneg, rneg, n2, ovf;
        longint unsigned on, od, an, ad, rn, rd, t1, t2, g, lim;
        t_frac_res       r;
        on_s = longint'($signed(n));
        od_s = longint'($signed(d));
        if (od_s == 0) begin
            on_s = 1;
            od_s = 1;
        end
        oneg = (on_s < 0) != (od_s < 0);
        on   = (on_s < 0) ? -on_s : on_s;
        od   = (od_s < 0) ? -od_s : od_s;
        aneg = acc_num < 0;
        an   = (acc_num < 0) ? -acc_num : acc_num;
        ad   = acc_den;
        ovf  = 1'b0;
        case (cmd)
            rar_pkg::CMD_SET: begin
                rneg = oneg; rn = on; rd = od;
            end
            rar_pkg::CMD_MUL: begin
                rneg = aneg != oneg; rn = an * on; rd = ad * od;
            end
            default: begin
                t1 = an * od;
                t2 = on * ad;
                n2 = (cmd == rar_pkg::CMD_SUB) ? !oneg : oneg;
                if (aneg == n2) begin
                    rneg = aneg; rn = t1 + t2;
                end else if (t1 >= t2) begin
                    rneg = aneg; rn = t1 - t2;
                end else begin
                    rneg = n2; rn = t2 - t1;
                end
                rd = ad * od;
            end
        endcase
        if (rn == 0) begin
            rneg = 1'b0;
            rd   = 1;
        end else begin
            g  = euclid_gcd(rn, rd);
            rn = rn / g;
            rd = rd / g;
        end
        lim = 64'd1 << 31;
        if (rd > lim - 1) ovf = 1'b1;
        if (rneg ? (rn > lim) : (rn > lim - 1)) ovf = 1'b1;
        if (!ovf) begin
            acc_num = rneg ? -longint'(rn) : longint'(rn);
            acc_den = longint'(rd);
        end
        r.num = acc_num[31:0];
        r.den = acc_den[30:0];
        r.ovf = ovf;
        return r;
    endfunction

    // Send one item, predicting its result at acceptance; starts and ends at a falling edge
    task automatic send_item(rar_pkg::t_cmd cmd, logic [31:0] n, logic [31:0] d, bit chk,
                             t_frac_res typed);
        while (!quiet_phase && $urandom_range(99) < 26) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, d, n, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        frac_expected_q.push_back(frac_update(cmd, n, d));
        typed_q.push_back(typed);
        typed_chk_q.push_back(chk);
        @(negedge i_clk);
    endtask

    // Random operand value: small values mostly, some full width and edges
    function automatic logic [31:0] rand_val();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'($signed($urandom_range(40)) - 20);
            4, 5:       return 32'($signed($urandom_range(2000)) - 1000);
            6:          return $urandom();
            7:          return {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom())};
            8:          return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default:    return 32'd0;
        endcase
    endfunction

    // Receiver: random stall, compare with oldest expectation
    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 26);
    end

    always @(posedge i_clk) begin
        t_frac_res got, exp_r, typ;
        bit        chk;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.num = m_axis_tdata[31:0];
            got.den = m_axis_tdata[62:32];
            got.ovf = m_axis_tuser[0];
            if (frac_expected_q.size() == 0) begin
                err_count++;
                if (err_count <= 10) $display("unexpected result %p", got);
            end else begin
                exp_r = frac_expected_q.pop_front();
                typ   = typed_q.pop_front();
                chk   = typed_chk_q.pop_front();
                if (got != exp_r || (chk && got != typ)) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: expected %p (typed %p) got %p", exp_r, typ, got);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || !i_rst_n || drain_phase)
            stall_cycles <= 0;
        else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("rational_accumulator_reduce test failed");
                $finish;
            end
        end
    end

    function automatic t_frac_res fr(logic [31:0] n, logic [30:0] d, logic o);
        t_frac_res r;
        r.num = n; r.den = d; r.ovf = o;
        return r;
    endfunction

    initial begin
        t_row          rows[$];
        rar_pkg::t_cmd cmd;
        int            k;
        quiet_phase   = 1'b0;
        drain_phase   = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        acc_num = 1;
        acc_den = 1;
        // Directed table: extremes, each command, zero and negative denominators
        rows = '{
            '{rar_pkg::CMD_ADD, 32'd0, 32'd0, 1, fr(32'd2, 31'd1, 0)},     // 1/1 + 1/1
            '{rar_pkg::CMD_SET, 32'd6, 32'd4, 1, fr(32'd3, 31'd2, 0)},     // reduced
            '{rar_pkg::CMD_SET, 32'd5, 32'hFFFF_FFFF, 1, fr(-32'sd5, 31'd1, 0)},
            '{rar_pkg::CMD_SET, 32'd0, 32'd7, 1, fr(32'd0, 31'd1, 0)},     // zero as 0/1
            '{rar_pkg::CMD_SET, 32'h8000_0000, 32'd1, 1, fr(32'h8000_0000, 31'd1, 0)},
            '{rar_pkg::CMD_SUB, 32'd1, 32'd1, 1, fr(32'h8000_0000, 31'd1, 1)},
            '{rar_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'd1, 1, fr(32'h8000_0000, 31'd1, 1)},
            '{rar_pkg::CMD_SET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, fr(32'd1, 31'd1, 0)},
            // denominator of 2^31 does not fit
            '{rar_pkg::CMD_SET, 32'd1, 32'h8000_0000, 1, fr(32'd1, 31'd1, 1)},
            '{rar_pkg::CMD_SET, 32'd1, 32'h7FFF_FFFF, 1, fr(32'd1, 31'h7FFF_FFFF, 0)},
            '{rar_pkg::CMD_MUL, 32'd1, 32'd2, 1, fr(32'd1, 31'h7FFF_FFFF, 1)},
            '{rar_pkg::CMD_ADD, 32'd3, 32'd5, 0, fr(0, 0, 0)},
            '{rar_pkg::CMD_SUB, 32'hFFFF_FFFD, 32'd7, 0, fr(0, 0, 0)},
            '{rar_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 0, fr(0, 0, 0)},
            '{rar_pkg::CMD_SET, 32'h7FFF_FFFF, 32'd1, 1, fr(32'h7FFF_FFFF, 31'd1, 0)},
            '{rar_pkg::CMD_ADD, 32'd1, 32'd0, 1, fr(32'h7FFF_FFFF, 31'd1, 1)},
            '{rar_pkg::CMD_SUB, 32'h7FFF_FFFF, 32'd1, 1, fr(32'd0, 31'd1, 0)},
            '{rar_pkg::CMD_MUL, 32'd9, 32'hFFFF_FFF7, 1, fr(32'd0, 31'd1, 0)},
            '{rar_pkg::CMD_SUB, 32'd2, 32'd3, 0, fr(0, 0, 0)},
            '{rar_pkg::CMD_ADD, 32'h5555_5555, 32'hAAAA_AAAA, 0, fr(0, 0, 0)}
        };
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].n, rows[i].d, rows[i].chk, rows[i].res);
        s_axis_tvalid <= 1'b0;
        // Sender holds off until every expected result has come
        while (frac_expected_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        for (k = 0; k < NUM_RANDOM; k++) begin
            quiet_phase = (k >= 600 && k < 800);
            cmd = rar_pkg::t_cmd'($urandom_range(3));
            send_item(cmd, rand_val(), rand_val(), 0, fr(0, 0, 0));
        end
        s_axis_tvalid <= 1'b0;
        quiet_phase = 1'b0;
        while (frac_expected_q.size() != 0) @(posedge i_clk);
        drain_phase = 1'b1;
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0 && frac_expected_q.size() == 0)
            $display("rational_accumulator_reduce test passed");
        else
            $display("rational_accumulator_reduce test failed");
        $finish;
    end
endmodule

@@ rational_accumulator_reduce.f @@
rtl/rar_pkg.sv
rtl/rar_front.sv
rtl/rar_fifo.sv
rtl/rar_core.sv
rtl/rational_accumulator_reduce.sv
tb/sv/rational_accumulator_reduce_tb.sv
